// ----- sv/atilt_pkg.sv -----
// Shared types, register codes and constant tables of the tilt angle block.
package atilt_pkg;

	// default widths
	localparam int FRAC_BITS_DEF   = 16;
	localparam int SAMPLE_BITS_DEF = 10;

	// configuration register indexes
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_Y_MAX = 3'd1;
	localparam logic [IDX_W-1:0] REG_Y_MIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_Z_MAX = 3'd3;
	localparam logic [IDX_W-1:0] REG_Z_MIN = 3'd4;

	// calibration reset values
	localparam int Y_MAX_RST = 986;
	localparam int Y_MIN_RST = 342;
	localparam int Z_MAX_RST = 866;
	localparam int Z_MIN_RST = 213;

	// angle arithmetic
	localparam int ANG_FRAC     = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int CORD_W       = 36;
	localparam int ANG_W        = 34;
	localparam int RAD_W        = 32;
	localparam logic [RAD_W-1:0] PI_Q30 = 32'd3373259426;

	// degree conversion: deg = rad * DEG_MUL / DEG_DIV
	localparam longint DEG_MUL   = 64'd1800000;
	localparam longint DEG_DIV   = 64'd31415 << 30;
	localparam int     RECIP_W   = 16;
	localparam logic [RECIP_W-1:0] DEG_RECIP = 16'd58672;
	localparam int     K_SHIFT   = 40;
	localparam int     DEG_TAB_N = 182;
	localparam int     DEG_IDX_W = 8;

	// selection of the final angle formula
	typedef enum logic [2:0] {
		SEL_FIXED,
		SEL_ACOS_POS,
		SEL_ACOS_NEG,
		SEL_ATAN_CEIL,
		SEL_ATAN_FLOOR
	} sel_t;

	// control word that travels with each item through the cells
	typedef struct packed {
		logic       valid;
		logic       mode;
		logic       span_err;
		sel_t       sel;
		logic [7:0] fixval;
	} ctl_t;

	typedef logic signed [ANG_W-1:0] atan_tab_t [10];
	localparam atan_tab_t ATAN_HEAD = '{
		34'sd843314857, 34'sd497837829, 34'sd263043836, 34'sd133525158,
		34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
		34'sd4194282,   34'sd2097149
	};

	// arctangent of 2^-i in radians, 30 fraction bits
	function automatic logic signed [ANG_W-1:0] atan_step(input int i);
		logic signed [ANG_W-1:0] t;
		if (i < 10) begin
			t = ATAN_HEAD[i];
		end else begin
			t = ANG_W'(1) << (ANG_FRAC - i);
		end
		return t;
	endfunction

	// radian thresholds of whole degrees: k*DEG_DIV/DEG_MUL rounded up or down
	typedef logic [RAD_W-1:0] thr_tab_t [DEG_TAB_N];
	function automatic thr_tab_t deg_thr(input bit round_up);
		thr_tab_t t;
		longint   p;
		for (int k = 0; k < DEG_TAB_N; k++) begin
			p = longint'(k) * DEG_DIV;
			if (round_up) begin
				t[k] = RAD_W'((p + DEG_MUL - 1) / DEG_MUL);
			end else begin
				t[k] = RAD_W'(p / DEG_MUL);
			end
		end
		return t;
	endfunction

	localparam thr_tab_t DEG_CEIL_TAB  = deg_thr(1'b1);
	localparam thr_tab_t DEG_FLOOR_TAB = deg_thr(1'b0);

endpackage

// ----- sv/atilt_div_cell.sv -----
// One restoring division step for the y and z mapping lanes.
module atilt_div_cell #(
	parameter int SB = 10,
	parameter int QW = 27
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  atilt_pkg::ctl_t       ctl_i,
	input  logic [1:0][SB-1:0]    rem_i,
	input  logic [1:0][QW-1:0]    dq_i,
	input  logic [1:0][SB-1:0]    dvs_i,
	input  logic [1:0]            sgn_i,
	output atilt_pkg::ctl_t       ctl_o,
	output logic [1:0][SB-1:0]    rem_o,
	output logic [1:0][QW-1:0]    dq_o,
	output logic [1:0][SB-1:0]    dvs_o,
	output logic [1:0]            sgn_o
);

	logic [1:0][SB-1:0] rem_nxt;
	logic [1:0][QW-1:0] dq_nxt;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		logic [SB:0] cand;
		logic [SB:0] diff;
		for (int l = 0; l < 2; l++) begin
			cand = {rem_i[l], dq_i[l][QW-1]};
			diff = cand - {1'b0, dvs_i[l]};
			if (cand >= {1'b0, dvs_i[l]}) begin
				rem_nxt[l] = diff[SB-1:0];
				dq_nxt[l]  = {dq_i[l][QW-2:0], 1'b1};
			end else begin
				rem_nxt[l] = cand[SB-1:0];
				dq_nxt[l]  = {dq_i[l][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_o <= rem_nxt;
		dq_o  <= dq_nxt;
		dvs_o <= dvs_i;
		sgn_o <= sgn_i;
	end

endmodule

// ----- sv/atilt_sqrt_cell.sv -----
// One digit step of the integer square root.
module atilt_sqrt_cell #(
	parameter int NW      = 33,
	parameter int PW      = 36,
	parameter int BIT_POS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  atilt_pkg::ctl_t ctl_i,
	input  logic [NW-1:0]   n_i,
	input  logic [NW:0]     r_i,
	input  logic [PW-1:0]   pass_i,
	output atilt_pkg::ctl_t ctl_o,
	output logic [NW-1:0]   n_o,
	output logic [NW:0]     r_o,
	output logic [PW-1:0]   pass_o
);

	localparam logic [NW:0] BIT = (NW+1)'(1) << BIT_POS;

	logic [NW:0]   trial;
	logic [NW-1:0] n_nxt;
	logic [NW:0]   r_nxt;

	// accept the digit when the remainder covers root plus bit
	always_comb begin
		trial = r_i + BIT;
		if ({1'b0, n_i} >= trial) begin
			n_nxt = n_i - trial[NW-1:0];
			r_nxt = (r_i >> 1) + BIT;
		end else begin
			n_nxt = n_i;
			r_nxt = r_i >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		n_o    <= n_nxt;
		r_o    <= r_nxt;
		pass_o <= pass_i;
	end

endmodule

// ----- sv/atilt_cordic_cell.sv -----
// One vectoring CORDIC rotation step.
module atilt_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  atilt_pkg::ctl_t                         ctl_i,
	input  logic signed [atilt_pkg::CORD_W-1:0]     x_i,
	input  logic signed [atilt_pkg::CORD_W-1:0]     y_i,
	input  logic signed [atilt_pkg::ANG_W-1:0]      z_i,
	output atilt_pkg::ctl_t                         ctl_o,
	output logic signed [atilt_pkg::CORD_W-1:0]     x_o,
	output logic signed [atilt_pkg::CORD_W-1:0]     y_o,
	output logic signed [atilt_pkg::ANG_W-1:0]      z_o
);

	localparam logic signed [atilt_pkg::ANG_W-1:0] ATAN = atilt_pkg::atan_step(STEP);

	logic signed [atilt_pkg::CORD_W-1:0] dx;
	logic signed [atilt_pkg::CORD_W-1:0] dy;
	logic signed [atilt_pkg::CORD_W-1:0] x_nxt;
	logic signed [atilt_pkg::CORD_W-1:0] y_nxt;
	logic signed [atilt_pkg::ANG_W-1:0]  z_nxt;

	// rotate toward the x axis, shifts round toward minus infinity
	always_comb begin
		dx = y_i >>> STEP;
		dy = x_i >>> STEP;
		if (!y_i[atilt_pkg::CORD_W-1]) begin
			x_nxt = x_i + dx;
			y_nxt = y_i - dy;
			z_nxt = z_i + ATAN;
		end else begin
			x_nxt = x_i - dx;
			y_nxt = y_i + dy;
			z_nxt = z_i - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		x_o <= x_nxt;
		y_o <= y_nxt;
		z_o <= z_nxt;
	end

endmodule

// ----- sv/accel_tilt_angle_top.sv -----
// Top level of the accelerometer tilt angle pipeline.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  input    | start, busy             | y_sample, z_sample
//  result   | done (one-cycle strobe) | angle_deg, span_error
//  config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// One item enters per cycle; busy stays low. The pipeline holds
// SAMPLE_BITS+FRAC_BITS+1 divider cells, FRAC_BITS+1 root cells, 30 CORDIC
// cells and 9 stage registers. Reset clears the calibration registers to
// their defaults and drops all valid flags. Results cannot be stalled; each
// appears for one cycle.
module accel_tilt_angle_top #(
	parameter int FRAC_BITS   = atilt_pkg::FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = atilt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [SAMPLE_BITS-1:0]      y_sample,
	input  logic [SAMPLE_BITS-1:0]      z_sample,
	output logic                        done,
	output logic [7:0]                  angle_deg,
	output logic                        span_error,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [atilt_pkg::IDX_W-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]      cfg_data
);

	localparam int SB   = SAMPLE_BITS;
	localparam int F    = FRAC_BITS;
	localparam int QW   = SB + F + 1;
	localparam int NW   = F + 2;
	localparam int RW   = 2 * F + 1;
	localparam int SQN  = F + 1;
	localparam int UP   = atilt_pkg::ANG_FRAC - F;
	localparam int CW   = atilt_pkg::CORD_W;
	localparam int AW   = atilt_pkg::ANG_W;
	localparam int DW   = atilt_pkg::RAD_W;
	localparam int NCOR = atilt_pkg::CORDIC_STEPS;
	localparam int SAT  = 1 << (F + 1);
	localparam int ONE  = 1 << F;

	// configuration registers
	logic          mode_q;
	logic [SB-1:0] y_max_q, y_min_q, z_max_q, z_min_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			y_max_q <= SB'(atilt_pkg::Y_MAX_RST);
			y_min_q <= SB'(atilt_pkg::Y_MIN_RST);
			z_max_q <= SB'(atilt_pkg::Z_MAX_RST);
			z_min_q <= SB'(atilt_pkg::Z_MIN_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				atilt_pkg::REG_MODE:  mode_q  <= cfg_data[0];
				atilt_pkg::REG_Y_MAX: y_max_q <= cfg_data;
				atilt_pkg::REG_Y_MIN: y_min_q <= cfg_data;
				atilt_pkg::REG_Z_MAX: z_max_q <= cfg_data;
				atilt_pkg::REG_Z_MIN: z_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1: offsets and spans as sign and magnitude
	logic signed [SB:0] y_num, z_num, y_spn, z_spn;
	logic signed [SB:0] y_num_n, z_num_n, y_spn_n, z_spn_n;
	atilt_pkg::ctl_t    ctl_in;

	always_comb begin
		y_num   = $signed({1'b0, y_sample}) - $signed({1'b0, y_min_q});
		z_num   = $signed({1'b0, z_sample}) - $signed({1'b0, z_min_q});
		y_spn   = $signed({1'b0, y_max_q}) - $signed({1'b0, y_min_q});
		z_spn   = $signed({1'b0, z_max_q}) - $signed({1'b0, z_min_q});
		y_num_n = -y_num;
		z_num_n = -z_num;
		y_spn_n = -y_spn;
		z_spn_n = -z_spn;
		ctl_in          = '0;
		ctl_in.valid    = start && !busy;
		ctl_in.mode     = mode_q;
		ctl_in.span_err = (y_max_q == y_min_q) || (mode_q && (z_max_q == z_min_q));
	end

	atilt_pkg::ctl_t    ctl_s1;
	logic [1:0][QW-1:0] dq_s1;
	logic [1:0][SB-1:0] dvs_s1;
	logic [1:0]         sgn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		dq_s1[0]  <= {(y_num[SB] ? y_num_n[SB-1:0] : y_num[SB-1:0]), (F+1)'(0)};
		dq_s1[1]  <= {(z_num[SB] ? z_num_n[SB-1:0] : z_num[SB-1:0]), (F+1)'(0)};
		dvs_s1[0] <= y_spn[SB] ? y_spn_n[SB-1:0] : y_spn[SB-1:0];
		dvs_s1[1] <= z_spn[SB] ? z_spn_n[SB-1:0] : z_spn[SB-1:0];
		sgn_s1[0] <= y_num[SB] ^ y_spn[SB];
		sgn_s1[1] <= z_num[SB] ^ z_spn[SB];
	end

	// divider cells, one quotient bit each
	atilt_pkg::ctl_t    dv_ctl [QW+1];
	logic [1:0][SB-1:0] dv_rem [QW+1];
	logic [1:0][QW-1:0] dv_dq  [QW+1];
	logic [1:0][SB-1:0] dv_dvs [QW+1];
	logic [1:0]         dv_sgn [QW+1];

	assign dv_ctl[0] = ctl_s1;
	assign dv_rem[0] = '0;
	assign dv_dq[0]  = dq_s1;
	assign dv_dvs[0] = dvs_s1;
	assign dv_sgn[0] = sgn_s1;

	for (genvar j = 0; j < QW; j++) begin : g_div
		atilt_div_cell #(.SB(SB), .QW(QW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_i(dv_ctl[j]), .rem_i(dv_rem[j]), .dq_i(dv_dq[j]),
			.dvs_i(dv_dvs[j]), .sgn_i(dv_sgn[j]),
			.ctl_o(dv_ctl[j+1]), .rem_o(dv_rem[j+1]), .dq_o(dv_dq[j+1]),
			.dvs_o(dv_dvs[j+1]), .sgn_o(dv_sgn[j+1])
		);
	end

	// s2: signed quotient, offset by one, saturated to Q2.F
	logic signed [1:0][NW-1:0] n_map;

	always_comb begin
		logic signed [QW+1:0] nq;
		logic signed [QW+1:0] nf;
		for (int l = 0; l < 2; l++) begin
			nq = $signed({2'b00, dv_dq[QW][l]});
			if (dv_sgn[QW][l]) begin
				nq = -nq;
			end
			nf = nq - $signed((QW+2)'(ONE));
			if (nf > $signed((QW+2)'(SAT - 1))) begin
				nf = $signed((QW+2)'(SAT - 1));
			end else if (nf < $signed((QW+2)'(-SAT))) begin
				nf = $signed((QW+2)'(-SAT));
			end
			n_map[l] = nf[NW-1:0];
		end
	end

	atilt_pkg::ctl_t    ctl_s2;
	logic signed [NW-1:0] ny_s2, nz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= dv_ctl[QW];
		end
	end

	always_ff @(posedge clk) begin
		ny_s2 <= n_map[0];
		nz_s2 <= n_map[1];
	end

	// s3: clamp, magnitudes and choice of the final formula
	logic signed [NW-1:0] xc, xc_n, ny_n, nz_n;
	logic [F:0]           ax;
	logic [NW-1:0]        ay, az;
	atilt_pkg::ctl_t      ctl_sel;

	always_comb begin
		xc = ny_s2;
		if (ny_s2 > $signed(NW'(ONE))) begin
			xc = $signed(NW'(ONE));
		end else if (ny_s2 < $signed(NW'(-ONE))) begin
			xc = $signed(NW'(-ONE));
		end
		xc_n = -xc;
		ny_n = -ny_s2;
		nz_n = -nz_s2;
		ax   = xc[NW-1] ? xc_n[F:0] : xc[F:0];
		ay   = ny_s2[NW-1] ? ny_n : ny_s2;
		az   = nz_s2[NW-1] ? nz_n : nz_s2;

		ctl_sel        = ctl_s2;
		ctl_sel.fixval = 8'd0;
		priority if (ctl_s2.span_err) begin
			ctl_sel.sel = atilt_pkg::SEL_FIXED;
		end else if (!ctl_s2.mode) begin
			ctl_sel.sel = xc[NW-1] ? atilt_pkg::SEL_ACOS_NEG : atilt_pkg::SEL_ACOS_POS;
		end else if (ny_s2 == '0) begin
			ctl_sel.sel    = atilt_pkg::SEL_FIXED;
			ctl_sel.fixval = 8'd90;
		end else if (ny_s2 < 0 && nz_s2 > 0) begin
			ctl_sel.sel    = atilt_pkg::SEL_FIXED;
			ctl_sel.fixval = 8'd180;
		end else if (ny_s2 > 0 && nz_s2 > 0) begin
			ctl_sel.sel = atilt_pkg::SEL_FIXED;
		end else if (ny_s2 < 0 && nz_s2 < 0) begin
			ctl_sel.sel = atilt_pkg::SEL_ATAN_CEIL;
		end else begin
			ctl_sel.sel = atilt_pkg::SEL_ATAN_FLOOR;
		end
	end

	atilt_pkg::ctl_t ctl_s3, ctl_s4, ctl_s5;
	logic [F:0]      ax_s3;
	logic [NW-1:0]   u_s3, vz_s3, u_s4, vz_s4, u_s5, vz_s5;
	logic [2*F+1:0]  xsq_s4;
	logic [RW-1:0]   rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s3 <= ctl_sel;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// s3 to s5: square, then radicand 1 - x^2
	always_ff @(posedge clk) begin
		ax_s3  <= ax;
		u_s3   <= ctl_s2.mode ? ay : NW'(ax);
		vz_s3  <= az;
		xsq_s4 <= (2*F+2)'(ax_s3) * (2*F+2)'(ax_s3);
		u_s4   <= u_s3;
		vz_s4  <= vz_s3;
		rad_s5 <= RW'(((2*F+2)'(1) << (2*F)) - xsq_s4);
		u_s5   <= u_s4;
		vz_s5  <= vz_s4;
	end

	// square root cells
	atilt_pkg::ctl_t  sq_ctl  [SQN+1];
	logic [RW-1:0]    sq_n    [SQN+1];
	logic [RW:0]      sq_r    [SQN+1];
	logic [2*NW-1:0]  sq_pass [SQN+1];

	assign sq_ctl[0]  = ctl_s5;
	assign sq_n[0]    = rad_s5;
	assign sq_r[0]    = '0;
	assign sq_pass[0] = {u_s5, vz_s5};

	for (genvar j = 0; j < SQN; j++) begin : g_sqrt
		atilt_sqrt_cell #(.NW(RW), .PW(2 * NW), .BIT_POS(2 * (F - j))) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_i(sq_ctl[j]), .n_i(sq_n[j]), .r_i(sq_r[j]), .pass_i(sq_pass[j]),
			.ctl_o(sq_ctl[j+1]), .n_o(sq_n[j+1]), .r_o(sq_r[j+1]),
			.pass_o(sq_pass[j+1])
		);
	end

	// s6: CORDIC operands scaled to 30 fraction bits
	atilt_pkg::ctl_t       ctl_s6;
	logic signed [CW-1:0]  cx_s6, cy_s6;
	logic [NW-1:0]         v_sel;

	assign v_sel = sq_ctl[SQN].mode ? sq_pass[SQN][NW-1:0] : NW'(sq_r[SQN][F:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
		end else begin
			ctl_s6 <= sq_ctl[SQN];
		end
	end

	always_ff @(posedge clk) begin
		cx_s6 <= $signed(CW'(sq_pass[SQN][2*NW-1:NW]) << UP);
		cy_s6 <= $signed(CW'(v_sel) << UP);
	end

	// CORDIC cells
	atilt_pkg::ctl_t      co_ctl [NCOR+1];
	logic signed [CW-1:0] co_x   [NCOR+1];
	logic signed [CW-1:0] co_y   [NCOR+1];
	logic signed [AW-1:0] co_z   [NCOR+1];

	assign co_ctl[0] = ctl_s6;
	assign co_x[0]   = cx_s6;
	assign co_y[0]   = cy_s6;
	assign co_z[0]   = '0;

	for (genvar i = 0; i < NCOR; i++) begin : g_cordic
		atilt_cordic_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_i(co_ctl[i]), .x_i(co_x[i]), .y_i(co_y[i]), .z_i(co_z[i]),
			.ctl_o(co_ctl[i+1]), .x_o(co_x[i+1]), .y_o(co_y[i+1]), .z_o(co_z[i+1])
		);
	end

	// s7: angle in radians, reflected for negative cosine
	logic [DW-1:0] zc;
	assign zc = co_z[NCOR][AW-1] ? '0 : co_z[NCOR][DW-1:0];

	atilt_pkg::ctl_t ctl_s7, ctl_s8;
	logic [DW-1:0]   rad_s7, rad_s8;
	logic [DW+atilt_pkg::RECIP_W-1:0] prod;
	logic [atilt_pkg::DEG_IDX_W-1:0]  kest_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else begin
			ctl_s7 <= co_ctl[NCOR];
			ctl_s8 <= ctl_s7;
		end
	end

	// s8: degree estimate from the reciprocal, at most one low
	assign prod = (DW+atilt_pkg::RECIP_W)'(rad_s7) * (DW+atilt_pkg::RECIP_W)'(atilt_pkg::DEG_RECIP);

	always_ff @(posedge clk) begin
		rad_s7  <= (co_ctl[NCOR].sel == atilt_pkg::SEL_ACOS_NEG) ? atilt_pkg::PI_Q30 - zc : zc;
		rad_s8  <= rad_s7;
		kest_s8 <= prod[atilt_pkg::K_SHIFT +: atilt_pkg::DEG_IDX_W];
	end

	// s9: exact floor and ceiling from threshold tables, then final angle
	logic [atilt_pkg::DEG_IDX_W-1:0] k1, dfl, dce, t_sub;
	logic       bump;
	logic [7:0] ang;

	always_comb begin
		k1   = kest_s8 + 1'b1;
		bump = rad_s8 >= atilt_pkg::DEG_CEIL_TAB[k1];
		dfl  = bump ? k1 : kest_s8;
		if (bump) begin
			dce = dfl + (rad_s8 > atilt_pkg::DEG_FLOOR_TAB[k1] ? 1'b1 : 1'b0);
		end else begin
			dce = dfl + (rad_s8 > atilt_pkg::DEG_FLOOR_TAB[kest_s8] ? 1'b1 : 1'b0);
		end
		t_sub = (dce >= 8'd180) ? 8'd0 : 8'd180 - dce;
		unique case (ctl_s8.sel)
			atilt_pkg::SEL_FIXED:      ang = ctl_s8.fixval;
			atilt_pkg::SEL_ACOS_POS,
			atilt_pkg::SEL_ACOS_NEG:   ang = (t_sub > 8'd135) ? 8'd135 : t_sub;
			atilt_pkg::SEL_ATAN_CEIL:  ang = t_sub;
			atilt_pkg::SEL_ATAN_FLOOR: ang = (dfl > 8'd180) ? 8'd180 : dfl;
			default:                   ang = 8'd0;
		endcase
	end

	logic       done_s9;
	logic [7:0] angle_s9;
	logic       err_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s9 <= 1'b0;
		end else begin
			done_s9 <= ctl_s8.valid;
		end
	end

	always_ff @(posedge clk) begin
		angle_s9 <= ang;
		err_s9   <= ctl_s8.span_err;
	end

	assign done       = done_s9;
	assign angle_deg  = angle_s9;
	assign span_error = err_s9;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the accelerometer tilt angle pipeline.
`timescale 1ns / 100ps

module tb;

	localparam int N_RANDOM = 1200;
	localparam int DRAIN    = 120;
	localparam int IW       = atilt_pkg::IDX_W;
	localparam longint ONE_Q = 64'sd65536;
	localparam longint PI_RAD = 64'sd3373259426;
	localparam longint DEG_NUM = 64'd1800000;
	localparam longint DEG_DEN = 64'd31415 << 30;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [9:0]           y_sample = '0;
	logic [9:0]           z_sample = '0;
	logic                 done;
	logic [7:0]           angle_deg;
	logic                 span_error;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IW-1:0]        cfg_index = atilt_pkg::REG_MODE;
	logic [9:0]           cfg_data = '0;

	typedef struct {
		logic [7:0] angle;
		logic       err;
	} tilt_t;

	// one row of directed stimulus: a register write or an item
	typedef struct {
		bit               is_wr;
		logic [IW-1:0]    idx;
		int               val;
		int               y;
		int               z;
		int               exp_ang;  // -1: use the predictor
		int               exp_err;
	} row_t;

	tilt_t       angle_q[$];
	logic        cur_mode = 1'b0;
	logic [9:0]  cur_ymax = 10'(atilt_pkg::Y_MAX_RST);
	logic [9:0]  cur_ymin = 10'(atilt_pkg::Y_MIN_RST);
	logic [9:0]  cur_zmax = 10'(atilt_pkg::Z_MAX_RST);
	logic [9:0]  cur_zmin = 10'(atilt_pkg::Z_MIN_RST);
	int          n_items = 0;
	int          n_results = 0;
	int          n_err_items = 0;
	int          n_mismatch = 0;
	row_t        pending_row;
	bit          use_row = 1'b0;

	const longint ATAN_TAB[10] = '{
		843314857, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149
	};

	accel_tilt_angle_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.y_sample   (y_sample),
		.z_sample   (z_sample),
		.done       (done),
		.angle_deg  (angle_deg),
		.span_error (span_error),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// linear map of a raw reading onto signed Q2.16, saturated
	function automatic longint axis_norm(longint s, longint hi, longint lo);
		longint n;
		n = ((s - lo) * 131072) / (hi - lo) - ONE_Q;
		if (n > 131071) n = 131071;
		if (n < -131072) n = -131072;
		return n;
	endfunction

	// vectoring arctangent of v/u, radians with 30 fraction bits
	function automatic longint cordic_atan(longint u, longint v);
		longint x, y, z, t, dx, dy;
		x = u; y = v; z = 0;
		for (int i = 0; i < 30; i++) begin
			t = (i < 10) ? ATAN_TAB[i] : (64'sd1 << (30 - i));
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += t;
			end else begin
				x -= dx; y += dy; z -= t;
			end
		end
		return (z < 0) ? 0 : z;
	endfunction

	function automatic longint rad_to_deg(longint rad, bit up);
		longint unsigned p;
		if (rad < 0) rad = 0;
		p = longint'(rad) * DEG_NUM;
		return up ? (p + DEG_DEN - 1) / DEG_DEN : p / DEG_DEN;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b; r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// expected angle for one sample pair under the current calibration
	function automatic tilt_t tilt_angle(logic [9:0] ys, logic [9:0] zs);
		tilt_t  r;
		longint x, s, rad, t, ny, nz, ang;
		r.err = 1'b0;
		ang = 0;
		if (cur_ymax == cur_ymin || (cur_mode && cur_zmax == cur_zmin)) begin
			r.angle = 8'd0;
			r.err = 1'b1;
			return r;
		end
		if (!cur_mode) begin
			x = axis_norm(ys, cur_ymax, cur_ymin);
			if (x > ONE_Q) x = ONE_Q;
			if (x < -ONE_Q) x = -ONE_Q;
			s = int_sqrt(ONE_Q * ONE_Q - x * x);
			if (x >= 0) rad = cordic_atan(x <<< 14, s <<< 14);
			else rad = PI_RAD - cordic_atan((-x) <<< 14, s <<< 14);
			t = rad_to_deg(rad, 1'b1);
			ang = (t >= 180) ? 0 : 180 - t;
			if (ang > 135) ang = 135;
		end else begin
			ny = axis_norm(ys, cur_ymax, cur_ymin);
			nz = axis_norm(zs, cur_zmax, cur_zmin);
			if (ny == 0) ang = 90;
			else if (ny < 0 && nz > 0) ang = 180;
			else if (ny > 0 && nz > 0) ang = 0;
			else begin
				rad = cordic_atan((ny < 0 ? -ny : ny) <<< 14, (nz < 0 ? -nz : nz) <<< 14);
				if (ny < 0 && nz < 0) begin
					t = rad_to_deg(rad, 1'b1);
					ang = (t >= 180) ? 0 : 180 - t;
				end else begin
					ang = rad_to_deg(rad, 1'b0);
					if (ang > 180) ang = 180;
				end
			end
		end
		r.angle = ang[7:0];
		return r;
	endfunction

	// register writes seen by the block update the predictor's copy
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				atilt_pkg::REG_MODE:  cur_mode <= cfg_data[0];
				atilt_pkg::REG_Y_MAX: cur_ymax <= cfg_data;
				atilt_pkg::REG_Y_MIN: cur_ymin <= cfg_data;
				atilt_pkg::REG_Z_MAX: cur_zmax <= cfg_data;
				atilt_pkg::REG_Z_MIN: cur_zmin <= cfg_data;
				default: ;
			endcase
		end
	end

	// accepted items: typed expectation or predicted one
	always @(posedge clk) begin
		tilt_t e;
		if (arst_n && start && !busy) begin
			e = tilt_angle(y_sample, z_sample);
			if (use_row && pending_row.exp_ang >= 0) begin
				e.angle = pending_row.exp_ang[7:0];
				e.err = pending_row.exp_err[0];
			end
			n_err_items += e.err;
			angle_q.push_back(e);
			n_items++;
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		tilt_t e;
		if (arst_n && done) begin
			n_results++;
			if (angle_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result: angle %0d err %0d", angle_deg, span_error);
			end else begin
				e = angle_q.pop_front();
				if (e.angle !== angle_deg || e.err !== span_error) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: expected angle %0d err %0d, got angle %0d err %0d",
							e.angle, e.err, angle_deg, span_error);
				end
			end
		end
	end

	task automatic send_item(int y, int z, int gap);
		@(negedge clk);
		start <= 1'b1;
		y_sample <= y[9:0];
		z_sample <= z[9:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop start and let every expected result come back
	task automatic drain_pipe();
		@(negedge clk);
		start <= 1'b0;
		while (angle_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [IW-1:0] idx, int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[9:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_cal();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1023;
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	function automatic int pick_sample(int a, int b);
		int lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1023);
		return $urandom_range(lo, hi);
	endfunction

	row_t rows[$];

	initial begin
		int burst, gap, ymx, ymn, zmx, zmn;

		// directed: reset calibration, both modes, quadrants, zero spans
		rows = '{
			'{0, atilt_pkg::REG_MODE, 0, 986, 0, 135, 0},
			'{0, atilt_pkg::REG_MODE, 0, 342, 1023, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 1023, 0, 135, 0},
			'{0, atilt_pkg::REG_MODE, 0, 0, 1023, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 664, 500, -1, 0},
			'{1, atilt_pkg::REG_MODE, 1, 0, 0, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 664, 0, 90, 0},
			'{0, atilt_pkg::REG_MODE, 0, 986, 866, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 342, 866, 180, 0},
			'{0, atilt_pkg::REG_MODE, 0, 342, 213, -1, 0},
			'{0, atilt_pkg::REG_MODE, 0, 986, 213, -1, 0},
			'{0, atilt_pkg::REG_MODE, 0, 1023, 1023, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 0, 0, -1, 0},
			'{1, atilt_pkg::REG_Z_MAX, 213, 0, 0, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 700, 300, 0, 1},
			'{1, atilt_pkg::REG_MODE, 0, 0, 0, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 700, 300, -1, 0},
			'{1, atilt_pkg::REG_Y_MAX, 342, 0, 0, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 1023, 0, 0, 1},
			'{1, atilt_pkg::REG_Y_MAX, 1023, 0, 0, 0, 0},
			'{1, atilt_pkg::REG_Y_MIN, 0, 0, 0, 0, 0},
			'{1, atilt_pkg::REG_Z_MAX, 0, 0, 0, 0, 0},
			'{1, atilt_pkg::REG_Z_MIN, 1023, 0, 0, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 511, 600, -1, 0},
			'{1, atilt_pkg::REG_MODE, 1, 0, 0, 0, 0},
			'{0, atilt_pkg::REG_MODE, 0, 200, 900, -1, 0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		use_row = 1'b1;
		foreach (rows[i]) begin
			// nonblocking, so an item accepted on this edge keeps its own row
			pending_row <= rows[i];
			if (rows[i].is_wr) begin
				drain_pipe();
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				send_item(rows[i].y, rows[i].z, $urandom_range(0, 2));
			end
		end
		drain_pipe();
		use_row = 1'b0;

		// random phases: new calibration each phase, bursty sender
		for (int ph = 0; ph < 8; ph++) begin
			drain_pipe();
			ymx = pick_cal(); ymn = pick_cal(); zmx = pick_cal(); zmn = pick_cal();
			if ($urandom_range(0, 9) == 0) ymn = ymx;
			if ($urandom_range(0, 9) == 0) zmn = zmx;
			write_reg(atilt_pkg::REG_MODE, $urandom_range(0, 1023));
			write_reg(atilt_pkg::REG_Y_MAX, ymx);
			write_reg(atilt_pkg::REG_Y_MIN, ymn);
			write_reg(atilt_pkg::REG_Z_MAX, zmx);
			write_reg(atilt_pkg::REG_Z_MIN, zmn);
			burst = 0;
			for (int k = 0; k < N_RANDOM / 8; k++) begin
				if (burst == 0) begin
					burst = $urandom_range(1, 24);
					gap = (ph == 3) ? 0 : $urandom_range(1, 6);
				end
				burst--;
				send_item(pick_sample(ymx, ymn), pick_sample(zmx, zmn), (burst == 0) ? gap : 0);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (angle_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("ran %0d items through both modes and %0d calibrations, %0d with a zero span",
			n_items, 9, n_err_items);
		$display("results checked: %0d, mismatches: %0d", n_results, n_mismatch);
		if (n_mismatch == 0 && angle_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("timeout with %0d results outstanding", angle_q.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/atilt_pkg.sv
sv/atilt_div_cell.sv
sv/atilt_sqrt_cell.sv
sv/atilt_cordic_cell.sv
sv/accel_tilt_angle_top.sv
bench/tb.sv
